FILE: rtl/core/geo_pkg.sv
// Shared constants, types and tables of the geodetic-to-geocentric core.
// No dependencies; all other core files but geo_delay import this package.
package geo_pkg;

    // Defaults of the top level parameters
    localparam int ANGLE_BITS_DEF     = 32;
    localparam int UNIT_FRAC_BITS_DEF = 30;
    localparam int COORD_BITS_DEF     = 40;

    // Fixed formats
    localparam int RADIUS_BITS  = 39;
    localparam int FIELD_BITS   = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_ZW    = 34;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int MUL_LAT      = 3;
    localparam int NORM_LAT     = 2;
    localparam int SQ_LAT       = 2;
    localparam int ROOT_BITS    = 32;
    localparam int ISQRT_LAT    = ROOT_BITS;
    localparam int NORM_BITS    = 31;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [63:0] GAIN_Q30 = 64'd652032874;
    localparam logic [RADIUS_BITS-1:0] EQ_RESET  = 39'd417997586432;
    localparam logic [RADIUS_BITS-1:0] POL_RESET = 39'd416596119666;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_EQ_RADIUS  = 2'd0,
        CFG_POL_RADIUS = 2'd1
    } t_cfg_reg;

    // Side information that rides along with the divider operands
    typedef struct packed {
        logic neg;
        logic zero;
    } t_div_ctl;

    // Side information of the normalized magnitudes
    typedef struct packed {
        logic neg_x;
        logic neg_z;
        logic zero;
    } t_norm_ctl;

    // CORDIC start value, gain in Q(frac)
    function automatic logic [63:0] gain_start(input int frac);
        logic [63:0] g;
        g = GAIN_Q30;
        if (frac >= 30) begin
            g = GAIN_Q30 << (frac - 30);
        end else begin
            g = GAIN_Q30 >> (30 - frac);
        end
        return g;
    endfunction

    // Arctangent of 2^-i, binary angle with 2^31 = pi
    function automatic logic [CORDIC_ZW-1:0] atan_at(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return {2'b00, v};
    endfunction

endpackage

FILE: rtl/core/geo_if.sv
// Valid/ready channel interfaces of the geodetic-to-geocentric core.
// Depends on geo_pkg for field and index widths.
interface geo_in_if import geo_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] latitude;
    logic signed [FIELD_BITS-1:0] longitude;
    logic signed [FIELD_BITS-1:0] elevation;
    modport source (output valid, latitude, longitude, elevation, input ready);
    modport sink   (input valid, latitude, longitude, elevation, output ready);
endinterface

interface geo_out_if import geo_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface geo_cfg_if import geo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [RADIUS_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/geo_delay.sv
// Enabled delay line that keeps side data aligned with the pipeline.
// Depends on nothing but its parameters.
module geo_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [N];

    // Advance all taps together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[N-1];
endmodule

FILE: rtl/core/geo_mulq.sv
// Pipelined signed multiplier with rounding shift (half away from zero).
// Two half-width partial products; imports geo_pkg.
module geo_mulq import geo_pkg::*; #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int SH = 30,
    parameter int WO = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [WA-1:0] i_a,
    input  logic signed [WB-1:0] i_b,
    output logic signed [WO-1:0] o_p
);
    localparam int HB = (WB + 1) / 2;
    localparam int HW = WB - HB;
    localparam int PW = WA + WB + 1;

    logic [WA-1:0]      r_ma;
    logic [WB-1:0]      r_mb;
    logic               r_neg1, r_neg2;
    logic [WA+HB-1:0]   r_pl;
    logic [WA+HW-1:0]   r_ph;
    logic [PW-1:0]      sum;
    logic [WO-1:0]      mag;
    logic signed [WO-1:0] r_p;

    // Stage 1: magnitudes and sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[WA-1] ? unsigned'(-i_a) : unsigned'(i_a);
            r_mb   <= i_b[WB-1] ? unsigned'(-i_b) : unsigned'(i_b);
            r_neg1 <= i_a[WA-1] ^ i_b[WB-1];
        end
    end

    // Stage 2: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl   <= r_ma * r_mb[HB-1:0];
            r_ph   <= r_ma * r_mb[WB-1:HB];
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: combine, round, restore the sign
    always_comb begin
        sum = PW'(r_pl) + (PW'(r_ph) << HB) + (PW'(1) << (SH - 1));
        mag = WO'(sum >> SH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg2 ? -signed'(mag) : signed'(mag);
        end
    end

    assign o_p = r_p;
endmodule

FILE: rtl/core/geo_cordic.sv
// Pipelined rotation CORDIC: sine and cosine of a 32-bit binary angle.
// One stage per step plus an output register; depends on geo_pkg.
module geo_cordic import geo_pkg::*; #(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [FIELD_BITS-1:0] i_angle,
    output logic signed [UNIT_FRAC_BITS+2:0] o_sin,
    output logic signed [UNIT_FRAC_BITS+2:0] o_cos
);
    localparam int W = UNIT_FRAC_BITS + 3;
    localparam int ZW = CORDIC_ZW;
    localparam logic signed [W-1:0] X0 = W'(gain_start(UNIT_FRAC_BITS));
    localparam logic signed [ZW-1:0] QTR = ZW'(64'h40000000);
    localparam logic signed [ZW-1:0] HALF = ZW'(64'h80000000);

    logic signed [W-1:0]  x_in [CORDIC_STEPS];
    logic signed [W-1:0]  y_in [CORDIC_STEPS];
    logic signed [ZW-1:0] z_in [CORDIC_STEPS];
    logic                 f_in [CORDIC_STEPS];
    logic signed [W-1:0]  r_x  [CORDIC_STEPS];
    logic signed [W-1:0]  r_y  [CORDIC_STEPS];
    logic signed [ZW-1:0] r_z  [CORDIC_STEPS];
    logic                 r_f  [CORDIC_STEPS];
    logic signed [ZW-1:0] z0;
    logic signed [W-1:0]  r_sin, r_cos;

    // Fold the angle into the right half plane
    always_comb begin
        z0 = ZW'(i_angle);
        z_in[0] = z0;
        f_in[0] = 1'b0;
        if (z0 > QTR) begin
            z_in[0] = z0 - HALF;
            f_in[0] = 1'b1;
        end else if (z0 < -QTR) begin
            z_in[0] = z0 + HALF;
            f_in[0] = 1'b1;
        end
        x_in[0] = X0;
        y_in[0] = '0;
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [W-1:0]  n_x, n_y;
        logic signed [ZW-1:0] n_z;
        logic signed [W-1:0]  dx, dy;

        always_comb begin
            dx = y_in[k] >>> k;
            dy = x_in[k] >>> k;
            if (z_in[k] >= 0) begin
                n_x = x_in[k] - dx;
                n_y = y_in[k] + dy;
                n_z = z_in[k] - signed'(atan_at(k));
            end else begin
                n_x = x_in[k] + dx;
                n_y = y_in[k] - dy;
                n_z = z_in[k] + signed'(atan_at(k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
                r_f[k] <= f_in[k];
            end
        end

        if (k + 1 < CORDIC_STEPS) begin : g_link
            assign x_in[k+1] = r_x[k];
            assign y_in[k+1] = r_y[k];
            assign z_in[k+1] = r_z[k];
            assign f_in[k+1] = r_f[k];
        end
    end

    // Undo the fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_f[CORDIC_STEPS-1] ? -r_y[CORDIC_STEPS-1] : r_y[CORDIC_STEPS-1];
            r_cos <= r_f[CORDIC_STEPS-1] ? -r_x[CORDIC_STEPS-1] : r_x[CORDIC_STEPS-1];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

FILE: rtl/core/geo_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on geo_pkg for the root width.
module geo_isqrt import geo_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2*ROOT_BITS-1:0] i_n,
    output logic [ROOT_BITS-1:0]   o_root
);
    localparam int NW = 2 * ROOT_BITS;

    logic [NW-1:0] n_in   [ROOT_BITS];
    logic [NW-1:0] res_in [ROOT_BITS];
    logic [NW-1:0] r_n    [ROOT_BITS];
    logic [NW-1:0] r_res  [ROOT_BITS];

    assign n_in[0]   = i_n;
    assign res_in[0] = '0;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
        localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
        logic [NW-1:0] trial, n_n, n_res;

        // Try the next root bit
        always_comb begin
            trial = res_in[k] + BIT;
            if (n_in[k] >= trial) begin
                n_n   = n_in[k] - trial;
                n_res = (res_in[k] >> 1) + BIT;
            end else begin
                n_n   = n_in[k];
                n_res = res_in[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= n_n;
                r_res[k] <= n_res;
            end
        end

        if (k + 1 < ROOT_BITS) begin : g_link
            assign n_in[k+1]   = r_n[k];
            assign res_in[k+1] = r_res[k];
        end
    end

    assign o_root = r_res[ROOT_BITS-1][ROOT_BITS-1:0];
endmodule

FILE: rtl/core/geo_div.sv
// Pipelined restoring divider: unit component num/den in Q(UNIT_FRAC_BITS).
// One quotient bit per stage, sign applied last; depends on geo_pkg.
module geo_div import geo_pkg::*; #(
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [NORM_BITS-1:0]           i_num,
    input  logic [ROOT_BITS-1:0]           i_den,
    input  t_div_ctl                       i_ctl,
    output logic signed [UNIT_FRAC_BITS+1:0] o_q
);
    localparam int NS = UNIT_FRAC_BITS + 1;
    localparam int RW = ROOT_BITS + 1;
    localparam int QW = UNIT_FRAC_BITS + 1;

    logic [RW-1:0]        rem_in [NS];
    logic [QW-1:0]        q_in   [NS];
    logic [ROOT_BITS-1:0] d_in   [NS];
    t_div_ctl             c_in   [NS];
    logic [RW-1:0]        r_rem  [NS];
    logic [QW-1:0]        r_q    [NS];
    logic [ROOT_BITS-1:0] r_d    [NS];
    t_div_ctl             r_c    [NS];
    logic signed [QW:0]   r_out;

    assign rem_in[0] = RW'(i_num);
    assign q_in[0]   = '0;
    assign d_in[0]   = i_den;
    assign c_in[0]   = i_ctl;

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [RW-1:0] sh;
        logic [RW-1:0] n_rem;
        logic [QW-1:0] n_q;

        // Shift in one bit (all but the first stage), subtract where it fits
        always_comb begin
            sh  = (k == 0) ? rem_in[k] : (rem_in[k] << 1);
            n_q = (k == 0) ? q_in[k] : (q_in[k] << 1);
            if (sh >= RW'(d_in[k])) begin
                n_rem = sh - RW'(d_in[k]);
                n_q   = n_q | QW'(1);
            end else begin
                n_rem = sh;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_d[k]   <= d_in[k];
                r_c[k]   <= c_in[k];
            end
        end

        if (k + 1 < NS) begin : g_link
            assign rem_in[k+1] = r_rem[k];
            assign q_in[k+1]   = r_q[k];
            assign d_in[k+1]   = r_d[k];
            assign c_in[k+1]   = r_c[k];
        end
    end

    // Put the sign back; a zero vector gives a zero component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_c[NS-1].zero) begin
                r_out <= '0;
            end else if (r_c[NS-1].neg) begin
                r_out <= -signed'({1'b0, r_q[NS-1]});
            end else begin
                r_out <= signed'({1'b0, r_q[NS-1]});
            end
        end
    end

    assign o_q = r_out;
endmodule

FILE: rtl/core/geodetic_to_geocentric_core.sv
// Top level of the geodetic-to-geocentric core: radius registers and the
// full pipeline. Depends on geo_pkg, geo_if and all geo_* units.
//
//  channel  | role | handshake     | payload
//  ---------+------+---------------+-------------------------------------
//  i_in     | sink | valid / ready | latitude, longitude, elevation
//  i_cfg    | sink | valid / ready | index (0 a, 1 b), data (39 bits)
//  o_res    | src  | valid / ready | x_coord, y_coord, z_coord
//
// One position enters per cycle while the output is not stalled. The path
// runs through the 32 CORDIC steps, the 32 root steps and the divider
// stages in series.
// Reset restores the WGS84 radii and empties the pipeline; no clearing pass.
// A result not taken freezes the whole pipeline; nothing is lost or repeated.
// i_cfg is always ready; writes to other indexes are dropped.
module geodetic_to_geocentric_core import geo_pkg::*; #(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    geo_in_if.sink      i_in,
    geo_cfg_if.sink     i_cfg,
    geo_out_if.source   o_res
);
    localparam int F   = UNIT_FRAC_BITS;
    localparam int WU  = F + 3;
    localparam int WQ  = F + 2;
    localparam int WR  = RADIUS_BITS + 1;
    localparam int WP  = RADIUS_BITS + 3;
    localparam int WH  = FIELD_BITS;
    localparam int WHS = FIELD_BITS + 2;
    localparam int LPW = $clog2(WP);
    localparam int SW  = ((COORD_BITS > WP) ? COORD_BITS : WP) + 2;
    localparam int DIV_LAT = F + 2;
    localparam int T1 = CORDIC_LAT;
    localparam int T2 = T1 + MUL_LAT;
    localparam int T3 = T2 + NORM_LAT;
    localparam int T4 = T3 + SQ_LAT;
    localparam int T5 = T4 + ISQRT_LAT;
    localparam int T6 = T5 + DIV_LAT;
    localparam int T7 = T6 + MUL_LAT;
    localparam int T8 = T7 + MUL_LAT;
    localparam logic signed [SW-1:0] SAT_HI =
        signed'({{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam int NW = 2 * NORM_BITS + $bits(t_norm_ctl);

    logic                       en, accept;
    logic [RADIUS_BITS-1:0]     r_eq, r_pol;
    logic signed [WR-1:0]       a_s, b_s;
    logic [T8-1:0]              r_vld;
    logic [FIELD_BITS-1:0]      lat_t, lon_t;

    logic signed [WU-1:0]  sl, cl, so, co;
    logic signed [WH-1:0]  h1, h7;
    logic signed [WP-1:0]  p, q;
    logic signed [WU-1:0]  cc, cs, cc7, cs7, so7, co7;
    logic signed [WHS-1:0] hs, hs8;

    logic [WP-1:0]          n_up, n_uq, m;
    logic [LPW-1:0]         n_lp;
    logic [WP-1:0]          r_up, r_uq;
    logic [LPW-1:0]         r_lp;
    t_norm_ctl              r_c1, r_nctl;
    logic [NORM_BITS-1:0]   n_upn, n_uqn, r_upn, r_uqn;
    logic [2*NORM_BITS-1:0] r_sqx, r_sqz;
    logic [2*ROOT_BITS-1:0] r_sum;
    logic [ROOT_BITS-1:0]   root;
    logic [NW-1:0]          nd;
    logic [NORM_BITS-1:0]   upn5, uqn5;
    t_norm_ctl              nctl5;
    t_div_ctl               dcx, dcz;
    logic signed [WQ-1:0]   ux, uz;
    logic signed [WP-1:0]   r7, zb, zb8, xr, yr;
    logic signed [WHS-1:0]  xh, yh;
    logic signed [SW-1:0]   sx, sy, sz;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic                   r_out_valid;

    // Advance the pipeline unless a finished result is stuck
    assign en          = !r_out_valid || o_res.ready;
    assign i_in.ready  = en;
    assign accept      = i_in.valid && en;
    assign i_cfg.ready = 1'b1;

    // Radius registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eq  <= EQ_RESET;
            r_pol <= POL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_EQ_RADIUS:  r_eq  <= i_cfg.data;
                CFG_POL_RADIUS: r_pol <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign a_s = signed'({1'b0, r_eq});
    assign b_s = signed'({1'b0, r_pol});

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[T8-2:0], accept};
        end
    end

    // Sine and cosine of both angles
    assign lat_t = i_in.latitude  << (FIELD_BITS - ANGLE_BITS);
    assign lon_t = i_in.longitude << (FIELD_BITS - ANGLE_BITS);

    geo_cordic #(.UNIT_FRAC_BITS(F)) u_cordic_lat (
        .i_clk(i_clk), .i_en(en), .i_angle(signed'(lat_t)), .o_sin(sl), .o_cos(cl)
    );
    geo_cordic #(.UNIT_FRAC_BITS(F)) u_cordic_lon (
        .i_clk(i_clk), .i_en(en), .i_angle(signed'(lon_t)), .o_sin(so), .o_cos(co)
    );
    geo_delay #(.W(WH), .N(T1)) u_dly_h1 (
        .i_clk(i_clk), .i_en(en), .i_d(i_in.elevation), .o_q(h1)
    );

    // First products: a cos lat, b sin lat, normal terms
    geo_mulq #(.WA(WR), .WB(WU), .SH(F), .WO(WP)) u_mul_p (
        .i_clk(i_clk), .i_en(en), .i_a(a_s), .i_b(cl), .o_p(p)
    );
    geo_mulq #(.WA(WR), .WB(WU), .SH(F), .WO(WP)) u_mul_q (
        .i_clk(i_clk), .i_en(en), .i_a(b_s), .i_b(sl), .o_p(q)
    );
    geo_mulq #(.WA(WU), .WB(WU), .SH(F), .WO(WU)) u_mul_cc (
        .i_clk(i_clk), .i_en(en), .i_a(cl), .i_b(co), .o_p(cc)
    );
    geo_mulq #(.WA(WU), .WB(WU), .SH(F), .WO(WU)) u_mul_cs (
        .i_clk(i_clk), .i_en(en), .i_a(cl), .i_b(so), .o_p(cs)
    );
    geo_mulq #(.WA(WH), .WB(WU), .SH(F), .WO(WHS)) u_mul_hs (
        .i_clk(i_clk), .i_en(en), .i_a(h1), .i_b(sl), .o_p(hs)
    );

    // Normalize, step 1: magnitudes and leading one
    always_comb begin
        n_up = p[WP-1] ? unsigned'(-p) : unsigned'(p);
        n_uq = q[WP-1] ? unsigned'(-q) : unsigned'(q);
        m    = (n_up > n_uq) ? n_up : n_uq;
        n_lp = '0;
        for (int i = 0; i < WP; i++) begin
            if (m[i]) begin
                n_lp = LPW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_up       <= n_up;
            r_uq       <= n_uq;
            r_lp       <= n_lp;
            r_c1.neg_x <= p[WP-1];
            r_c1.neg_z <= q[WP-1];
            r_c1.zero  <= (m == '0);
        end
    end

    // Normalize, step 2: shift the larger into [2^30, 2^31)
    always_comb begin
        if (r_lp > LPW'(NORM_BITS - 1)) begin
            n_upn = NORM_BITS'(r_up >> (r_lp - LPW'(NORM_BITS - 1)));
            n_uqn = NORM_BITS'(r_uq >> (r_lp - LPW'(NORM_BITS - 1)));
        end else begin
            n_upn = NORM_BITS'(r_up << (LPW'(NORM_BITS - 1) - r_lp));
            n_uqn = NORM_BITS'(r_uq << (LPW'(NORM_BITS - 1) - r_lp));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_upn  <= n_upn;
            r_uqn  <= n_uqn;
            r_nctl <= r_c1;
        end
    end

    // Sum of squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= r_upn * r_upn;
            r_sqz <= r_uqn * r_uqn;
            r_sum <= (2*ROOT_BITS)'(r_sqx) + (2*ROOT_BITS)'(r_sqz);
        end
    end

    geo_isqrt u_isqrt (
        .i_clk(i_clk), .i_en(en), .i_n(r_sum), .o_root(root)
    );
    geo_delay #(.W(NW), .N(T5 - T3)) u_dly_norm (
        .i_clk(i_clk), .i_en(en), .i_d({r_upn, r_uqn, r_nctl}), .o_q(nd)
    );
    assign {upn5, uqn5, nctl5} = nd;
    assign dcx = '{neg: nctl5.neg_x, zero: nctl5.zero};
    assign dcz = '{neg: nctl5.neg_z, zero: nctl5.zero};

    // Unit vector components
    geo_div #(.UNIT_FRAC_BITS(F)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(upn5), .i_den(root), .i_ctl(dcx), .o_q(ux)
    );
    geo_div #(.UNIT_FRAC_BITS(F)) u_div_z (
        .i_clk(i_clk), .i_en(en), .i_num(uqn5), .i_den(root), .i_ctl(dcz), .o_q(uz)
    );

    // Surface point radius and height
    geo_mulq #(.WA(WR), .WB(WQ), .SH(F), .WO(WP)) u_mul_r (
        .i_clk(i_clk), .i_en(en), .i_a(a_s), .i_b(ux), .o_p(r7)
    );
    geo_mulq #(.WA(WR), .WB(WQ), .SH(F), .WO(WP)) u_mul_zb (
        .i_clk(i_clk), .i_en(en), .i_a(b_s), .i_b(uz), .o_p(zb)
    );

    // Align longitude terms, elevation and normal products
    geo_delay #(.W(WU), .N(T7 - T1)) u_dly_so (
        .i_clk(i_clk), .i_en(en), .i_d(so), .o_q(so7)
    );
    geo_delay #(.W(WU), .N(T7 - T1)) u_dly_co (
        .i_clk(i_clk), .i_en(en), .i_d(co), .o_q(co7)
    );
    geo_delay #(.W(WH), .N(T7 - T1)) u_dly_h7 (
        .i_clk(i_clk), .i_en(en), .i_d(h1), .o_q(h7)
    );
    geo_delay #(.W(WU), .N(T7 - T2)) u_dly_cc (
        .i_clk(i_clk), .i_en(en), .i_d(cc), .o_q(cc7)
    );
    geo_delay #(.W(WU), .N(T7 - T2)) u_dly_cs (
        .i_clk(i_clk), .i_en(en), .i_d(cs), .o_q(cs7)
    );
    geo_delay #(.W(WHS), .N(T8 - T2)) u_dly_hs (
        .i_clk(i_clk), .i_en(en), .i_d(hs), .o_q(hs8)
    );
    geo_delay #(.W(WP), .N(MUL_LAT)) u_dly_zb (
        .i_clk(i_clk), .i_en(en), .i_d(zb), .o_q(zb8)
    );

    // Last products
    geo_mulq #(.WA(WP), .WB(WU), .SH(F), .WO(WP)) u_mul_xr (
        .i_clk(i_clk), .i_en(en), .i_a(r7), .i_b(co7), .o_p(xr)
    );
    geo_mulq #(.WA(WP), .WB(WU), .SH(F), .WO(WP)) u_mul_yr (
        .i_clk(i_clk), .i_en(en), .i_a(r7), .i_b(so7), .o_p(yr)
    );
    geo_mulq #(.WA(WH), .WB(WU), .SH(F), .WO(WHS)) u_mul_xh (
        .i_clk(i_clk), .i_en(en), .i_a(h7), .i_b(cc7), .o_p(xh)
    );
    geo_mulq #(.WA(WH), .WB(WU), .SH(F), .WO(WHS)) u_mul_yh (
        .i_clk(i_clk), .i_en(en), .i_a(h7), .i_b(cs7), .o_p(yh)
    );

    // Add point and normal term
    always_comb begin
        sx = SW'(xr) + SW'(xh);
        sy = SW'(yr) + SW'(yh);
        sz = SW'(zb8) + SW'(hs8);
    end

    // Saturate into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x <= (sx > SAT_HI) ? COORD_BITS'(SAT_HI) :
                   (sx < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(sx);
            r_y <= (sy > SAT_HI) ? COORD_BITS'(SAT_HI) :
                   (sy < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(sy);
            r_z <= (sz > SAT_HI) ? COORD_BITS'(SAT_HI) :
                   (sz < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(sz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[T8-1];
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.x_coord = r_x;
    assign o_res.y_coord = r_y;
    assign o_res.z_coord = r_z;

    // Normalized magnitudes keep their leading one in bit 30
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[T3-1] && !r_nctl.zero) |-> (r_upn[NORM_BITS-1] || r_uqn[NORM_BITS-1]))
        else $error("normalized magnitude out of range");

    // Vector length of a normalized pair is at least 2^30
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[T5-1] && !nctl5.zero) |-> (root[ROOT_BITS-1] || root[ROOT_BITS-2]))
        else $error("root below normalized range");

    // Unit components stay within one
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[T6-1] |-> ((ux <= (WQ'(1) <<< F)) && (ux >= -(WQ'(1) <<< F)) &&
                         (uz <= (WQ'(1) <<< F)) && (uz >= -(WQ'(1) <<< F))))
        else $error("unit component exceeds one");

    // Writes to unused indexes leave the radii alone
    a_cfg_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && (i_cfg.index != CFG_EQ_RADIUS) && (i_cfg.index != CFG_POL_RADIUS))
        |=> ($stable(r_eq) && $stable(r_pol)))
        else $error("radius changed by unused index");
endmodule

FILE: bench/geo_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the geodetic-to-geocentric core: a bit-exact coordinate
// predictor and a queue of expected positions. Depends on geo_pkg.
package geo_scoreboard_pkg;
    import geo_pkg::*;

    typedef struct packed {
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [39:0] z;
    } t_ecef;

    class geo_scoreboard;
        longint unsigned eq_radius;
        longint unsigned pol_radius;
        t_ecef           pending[$];
        int              mismatches;

        function new();
            eq_radius  = EQ_RESET;
            pol_radius = POL_RESET;
            mismatches = 0;
        endfunction

        function void set_radius(logic [CFG_IDX_BITS-1:0] idx, logic [RADIUS_BITS-1:0] v);
            if (idx == CFG_EQ_RADIUS) eq_radius = v;
            else if (idx == CFG_POL_RADIUS) pol_radius = v;
        endfunction

        static function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        // round(a*b / 2^s), half away from zero, saturated to 63 bits
        static function longint mul_round(longint a, longint b, int s);
            logic [127:0] ua, ub, pr;
            logic         neg;
            logic [127:0] r;
            neg = (a < 0) != (b < 0);
            ua  = a < 0 ? 128'(-a) : 128'(a);
            ub  = b < 0 ? 128'(-b) : 128'(b);
            pr  = ua * ub + (128'd1 << (s - 1));
            r   = pr >> s;
            if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
            return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
        endfunction

        static function void rotate(logic [31:0] ang, output longint sn, output longint cs);
            longint x, y, z, dx, dy;
            bit     flip;
            z = longint'($signed(ang));
            x = longint'(GAIN_Q30);
            y = 0;
            flip = 0;
            if (z > 64'sh40000000) begin
                z -= 64'sh80000000; flip = 1;
            end else if (z < -64'sh40000000) begin
                z += 64'sh80000000; flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(atan_at(i));
                end else begin
                    x += dx; y -= dy; z += longint'(atan_at(i));
                end
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        static function longint unsigned int_root(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        static function longint unit_div(longint unsigned num, longint unsigned den, bit neg);
            longint unsigned rem, q;
            rem = num; q = 0;
            if (rem >= den) begin
                rem -= den; q = 1;
            end
            for (int i = 0; i < 30; i++) begin
                rem <<= 1; q <<= 1;
                if (rem >= den) begin
                    rem -= den; q |= 1;
                end
            end
            return neg ? -longint'(q) : longint'(q);
        endfunction

        static function logic signed [39:0] clamp40(longint v);
            if (v > 64'sh7F_FFFF_FFFF) v = 64'sh7F_FFFF_FFFF;
            if (v < -64'sh80_0000_0000) v = -64'sh80_0000_0000;
            return v[39:0];
        endfunction

        // Predict the coordinates of one accepted position
        function void note_position(logic [31:0] lat, logic [31:0] lon, logic [31:0] elev);
            longint sl, cl, so, co, p, q, ux, uz, r, h, a, b;
            longint unsigned up, uq, m, d;
            t_ecef e;
            a = eq_radius; b = pol_radius;
            rotate(lat, sl, cl);
            rotate(lon, so, co);
            h  = longint'($signed(elev));
            ux = 0; uz = 0;
            p  = mul_round(a, cl, 30);
            q  = mul_round(b, sl, 30);
            up = p < 0 ? -p : p;
            uq = q < 0 ? -q : q;
            m  = up > uq ? up : uq;
            if (m != 0) begin
                while (m >= (64'd1 << 31)) begin
                    up >>= 1; uq >>= 1; m >>= 1;
                end
                while (m < (64'd1 << 30)) begin
                    up <<= 1; uq <<= 1; m <<= 1;
                end
                d  = int_root(up * up + uq * uq);
                ux = unit_div(up, d, p < 0);
                uz = unit_div(uq, d, q < 0);
            end
            r   = mul_round(a, ux, 30);
            e.x = clamp40(mul_round(r, co, 30) + mul_round(h, mul_round(cl, co, 30), 30));
            e.y = clamp40(mul_round(r, so, 30) + mul_round(h, mul_round(cl, so, 30), 30));
            e.z = clamp40(mul_round(b, uz, 30) + mul_round(h, sl, 30));
            pending.push_back(e);
        endfunction

        // Compare one result with the oldest prediction
        function void check_result(logic [39:0] x, logic [39:0] y, logic [39:0] z);
            t_ecef e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h %h", x, y, z);
                return;
            end
            e = pending.pop_front();
            if (e.x !== x || e.y !== y || e.z !== z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h %h %h got %h %h %h", e.x, e.y, e.z, x, y, z);
            end
        endfunction
    endclass
endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the geodetic-to-geocentric core bench: clock, reset, stimulus,
// output sink and watchdog. Depends on geo_pkg, geo_if and geo_scoreboard_pkg.
module tb_top;
    import geo_pkg::*;
    import geo_scoreboard_pkg::*;

    localparam int LATENCY  = 111;
    localparam int WATCHDOG = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #5 i_clk = ~i_clk;

    geo_in_if  in_ch();
    geo_cfg_if cfg_ch();
    geo_out_if out_ch();

    geodetic_to_geocentric_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_cfg(cfg_ch), .o_res(out_ch)
    );

    geo_scoreboard sb = new();
    int  idle_pct = 21;
    int  hold_off = 0;
    int  quiet = 0;
    bit  done = 0;

    initial begin
        in_ch.valid = 0; in_ch.latitude = 0; in_ch.longitude = 0; in_ch.elevation = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        out_ch.ready = 0;
    end

    // Sink: random idling plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.x_coord, out_ch.y_coord, out_ch.z_coord);
    end

    // Watchdog: cycles with no transfer on the input or output channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_pos(logic [31:0] lat, logic [31:0] lon, logic [31:0] elev);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.latitude <= lat; in_ch.longitude <= lon; in_ch.elevation <= elev;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_position(lat, lon, elev);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [CFG_IDX_BITS-1:0] idx, logic [RADIUS_BITS-1:0] v);
        cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_radius(idx, v);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(5))
            0: return 32'h4000_0000 + $urandom_range(8) - 4;
            1: return 32'hC000_0000 + $urandom_range(8) - 4;
            2: return {$urandom_range(1) ? 2'b11 : 2'b00, 30'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [38:0] pick_radius();
        case ($urandom_range(4))
            0: return 39'd1;
            1: return '1;
            2: return 39'($urandom_range(1000));
            default: return {7'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            logic [31:0] e;
            e = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                         : $urandom;
            send_pos(pick_angle(), $urandom, e);
        end
    endtask

    logic [31:0] edge_vals[6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h4000_0000, 32'hC000_0000, 32'hFFFF_FFFF};

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extreme angles and elevations on reset radii
        for (int i = 0; i < 6; i++)
            send_pos(edge_vals[i], edge_vals[(i + 2) % 6], edge_vals[(i + 1) % 6]);
        send_pos(32'h4000_0001, 32'h2000_0000, 32'h0);
        send_pos(32'hBFFF_FFFF, 32'h6000_0000, 32'h1000_0000);
        drain();

        // Zero radii collapse the surface; index 2 and 3 are dropped
        write_radius(CFG_EQ_RADIUS, 39'd0);
        write_radius(CFG_POL_RADIUS, 39'd0);
        write_radius(2'd2, '1);
        write_radius(2'd3, 39'd5);
        for (int i = 0; i < 4; i++) send_pos(edge_vals[i], edge_vals[i + 1], edge_vals[i + 2]);
        drain();

        // Largest radii saturate the coordinates
        write_radius(CFG_EQ_RADIUS, '1);
        write_radius(CFG_POL_RADIUS, '1);
        for (int i = 0; i < 6; i++) send_pos(edge_vals[i], edge_vals[5 - i], 32'h7FFF_FFFF);
        drain();

        // Back to WGS84 with no idling, then a long receiver hold-off
        write_radius(CFG_EQ_RADIUS, EQ_RESET);
        write_radius(CFG_POL_RADIUS, POL_RESET);
        idle_pct = 0;
        random_batch(200);
        hold_off = 400;
        random_batch(300);
        idle_pct = 21;
        drain();

        // Random phases over several radius settings
        for (int ph = 0; ph < 7; ph++) begin
            write_radius(CFG_EQ_RADIUS, pick_radius());
            write_radius(CFG_POL_RADIUS, pick_radius());
            random_batch(200);
            drain();
        end
        write_radius(CFG_EQ_RADIUS, EQ_RESET);
        write_radius(CFG_POL_RADIUS, POL_RESET);
        random_batch(50);

        drain();
        repeat (LATENCY) @(posedge i_clk);
        done = 1;
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/geo_pkg.sv
rtl/core/geo_if.sv
rtl/core/geo_delay.sv
rtl/core/geo_mulq.sv
rtl/core/geo_cordic.sv
rtl/core/geo_isqrt.sv
rtl/core/geo_div.sv
rtl/core/geodetic_to_geocentric_core.sv
bench/geo_scoreboard.sv
bench/tb_top.sv
